// ----- sv/rspc_pkg.sv -----
`default_nettype none

package rspc_pkg;

    // default sampling grid and coordinate width
    localparam int GRID_SIDE   = 4;
    localparam int COORD_BITS  = 10;

    // fixed field widths
    localparam int RADIUS_BITS = 12;
    localparam int WIDTH_BITS  = 8;
    localparam int COLOR_BITS  = 8;
    localparam int OUT_XY_BITS = 10;
    localparam int COV_BITS    = 5;

    // stroke width after reset, 4.0 pixels in 1/16 pixel
    localparam logic [WIDTH_BITS-1:0] RING_WIDTH_RESET = WIDTH_BITS'(64);

    // squared distances carry a factor of 16*16 against the reduced offsets
    localparam int DIST_SQ_SHIFT = 8;

endpackage

`default_nettype wire

// ----- sv/rspc_ifs.sv -----
`default_nettype none

// pixel request channel
interface rspc_in_if #(
    parameter int COORD_BITS = rspc_pkg::COORD_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic [COORD_BITS-1:0]                 pixel_x;
    logic [COORD_BITS-1:0]                 pixel_y;
    logic signed [COORD_BITS:0]            center_x;
    logic signed [COORD_BITS:0]            center_y;
    logic [rspc_pkg::RADIUS_BITS-1:0]      ring_radius;
    logic [rspc_pkg::COLOR_BITS-1:0]       red_in;
    logic [rspc_pkg::COLOR_BITS-1:0]       green_in;
    logic [rspc_pkg::COLOR_BITS-1:0]       blue_in;

    modport source (
        output valid, pixel_x, pixel_y, center_x, center_y, ring_radius,
               red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, center_x, center_y, ring_radius,
               red_in, green_in, blue_in,
        output ready
    );
endinterface

// shaded pixel channel
interface rspc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [rspc_pkg::OUT_XY_BITS-1:0]      out_x;
    logic [rspc_pkg::OUT_XY_BITS-1:0]      out_y;
    logic [rspc_pkg::COV_BITS-1:0]         coverage;
    logic [rspc_pkg::COLOR_BITS-1:0]       red_out;
    logic [rspc_pkg::COLOR_BITS-1:0]       green_out;
    logic [rspc_pkg::COLOR_BITS-1:0]       blue_out;

    modport source (
        output valid, out_x, out_y, coverage, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, coverage, red_out, green_out, blue_out,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/supersampled_ring_pixel_coverage_unit.sv -----
// Antialiased ring coverage for one pixel, supersampled on a GRID_SIDE x GRID_SIDE grid.
// i_pix carries one pixel coordinate with the ring centre, mid radius and colour;
// a transfer happens on a clock edge with valid and ready both high.
// o_pix returns the pixel position, the number of covered subsamples and the colour
// scaled by coverage/(GRID_SIDE^2). A pixel with no covered subsample gives no transfer.
// The stroke width is a register written through i_cfg_wr_en/i_cfg_wr_data; write it
// only while no pixel is in flight.
// Pipeline: eight register stages between an input transfer and the result on o_pix
// (subtract, sample offsets, squares, sums and thresholds, compares, hit count,
// colour product, reciprocal scale into the output register).
// Throughput: one pixel per clock while o_pix takes each result; every stage holds one pixel and its valid bit.
// Stalls: when o_pix is not taken the output holds steady and the stages behind it
// keep filling any empty slot, so i_pix stays ready until the whole pipe is full.
// Reset (i_rst_n low, synchronous) empties the pipe and sets the width to 4.0 pixels.
`default_nettype none

module supersampled_ring_pixel_coverage_unit #(
    parameter int GRID_SIDE  = rspc_pkg::GRID_SIDE,
    parameter int COORD_BITS = rspc_pkg::COORD_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rspc_pkg::WIDTH_BITS-1:0]   i_cfg_wr_data,
    rspc_in_if.sink                                i_pix,
    rspc_out_if.source                             o_pix
);

    localparam int NSTG    = 8;
    localparam int LAST    = NSTG - 1;
    localparam int TOTAL   = GRID_SIDE * GRID_SIDE;
    localparam int CB      = rspc_pkg::COLOR_BITS;
    localparam int DIFF_W  = COORD_BITS + 2;
    localparam int U_W     = DIFF_W + $clog2(2 * GRID_SIDE) + 1;
    localparam int SQ_W    = 2 * U_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RAD_W   = rspc_pkg::RADIUS_BITS + 2;
    localparam int RSQ_W   = 2 * RAD_W;
    localparam int THR_W   = RSQ_W + $clog2(TOTAL + 1);
    localparam int LHS_W   = SUM_W + rspc_pkg::DIST_SQ_SHIFT;
    localparam int CMP_W   = (LHS_W > THR_W) ? LHS_W : THR_W;
    localparam int HIT_W   = $clog2(TOTAL + 1);
    localparam int PROD_W  = CB + HIT_W;
    localparam int REC_K   = PROD_W + $clog2(TOTAL);
    localparam int REC_M   = ((1 << REC_K) + TOTAL - 1) / TOTAL;
    localparam int REC_W   = REC_K + 1;
    localparam int PQ_W    = PROD_W + REC_W;
    localparam int SIDE_W  = 2 * COORD_BITS + 3 * CB;
    localparam int PY_LO   = 3 * CB;
    localparam int PX_LO   = PY_LO + COORD_BITS;

    localparam logic signed [U_W-1:0] TWO_G = U_W'(2 * GRID_SIDE);

    // stroke width register
    logic [rspc_pkg::WIDTH_BITS-1:0] r_ring_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_width <= rspc_pkg::RING_WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_ring_width <= i_cfg_wr_data;
        end
    end

    // per-stage valid bits and advance chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;
    logic [HIT_W-1:0] r_hits6;

    always_comb begin
        adv[LAST] = !r_vld[LAST] || o_pix.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_pix.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < LAST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            // drop pixels with no covered subsample
            if (adv[LAST]) begin
                r_vld[LAST] <= r_vld[LAST-1] && (r_hits6 != '0);
            end
        end
    end

    // position and colour travel alongside the arithmetic
    logic [SIDE_W-1:0] r_side [NSTG];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_side[0] <= {i_pix.pixel_x, i_pix.pixel_y,
                          i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
        for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage 0: offsets from centre and ring bounds in 1/32 pixel
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [RAD_W-1:0]  r_rin0;
    logic [RAD_W-1:0]         r_rout0;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dx    <= DIFF_W'(signed'({1'b0, i_pix.pixel_x})) - DIFF_W'(i_pix.center_x);
            r_dy    <= DIFF_W'(signed'({1'b0, i_pix.pixel_y})) - DIFF_W'(i_pix.center_y);
            r_rin0  <= signed'({1'b0, i_pix.ring_radius, 1'b0})
                       - signed'(RAD_W'(r_ring_width));
            r_rout0 <= RAD_W'({i_pix.ring_radius, 1'b0}) + RAD_W'(r_ring_width);
        end
    end

    // stage 1: subsample offsets, 2*G*diff + 2*k - G per row and column
    logic signed [U_W-1:0]    r_ux [GRID_SIDE];
    logic signed [U_W-1:0]    r_uy [GRID_SIDE];
    logic signed [RAD_W-1:0]  r_rin1;
    logic [RAD_W-1:0]         r_rout1;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int a = 0; a < GRID_SIDE; a++) begin
                r_ux[a] <= U_W'(r_dx) * TWO_G + U_W'(2 * a - GRID_SIDE);
                r_uy[a] <= U_W'(r_dy) * TWO_G + U_W'(2 * a - GRID_SIDE);
            end
            r_rin1  <= r_rin0;
            r_rout1 <= r_rout0;
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0]  r_sqx [GRID_SIDE];
    logic [SQ_W-1:0]  r_sqy [GRID_SIDE];
    logic [RSQ_W-1:0] r_rin_sq;
    logic [RSQ_W-1:0] r_rout_sq;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int a = 0; a < GRID_SIDE; a++) begin
                r_sqx[a] <= SQ_W'(r_ux[a]) * SQ_W'(r_ux[a]);
                r_sqy[a] <= SQ_W'(r_uy[a]) * SQ_W'(r_uy[a]);
            end
            r_rin_sq  <= RSQ_W'(r_rin1) * RSQ_W'(r_rin1);
            r_rout_sq <= RSQ_W'(r_rout1) * RSQ_W'(r_rout1);
        end
    end

    // stage 3: squared distance per subsample, bounds scaled by G^2
    logic [SUM_W-1:0] r_sum [TOTAL];
    logic [CMP_W-1:0] r_thr_in;
    logic [CMP_W-1:0] r_thr_out;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int a = 0; a < GRID_SIDE; a++) begin
                for (int b = 0; b < GRID_SIDE; b++) begin
                    r_sum[a*GRID_SIDE+b] <= SUM_W'(r_sqx[a]) + SUM_W'(r_sqy[b]);
                end
            end
            r_thr_in  <= CMP_W'(r_rin_sq) * CMP_W'(TOTAL);
            r_thr_out <= CMP_W'(r_rout_sq) * CMP_W'(TOTAL);
        end
    end

    // stage 4: strict inside-ring test per subsample
    logic [TOTAL-1:0] n_hit;
    logic [TOTAL-1:0] r_hit;

    always_comb begin
        logic [CMP_W-1:0] lhs;
        for (int i = 0; i < TOTAL; i++) begin
            lhs      = CMP_W'(r_sum[i]) << rspc_pkg::DIST_SQ_SHIFT;
            n_hit[i] = (lhs > r_thr_in) && (lhs < r_thr_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_hit <= n_hit;
        end
    end

    // stage 5: hit count
    logic [HIT_W-1:0] n_hits;
    logic [HIT_W-1:0] r_hits5;

    always_comb begin
        n_hits = '0;
        for (int i = 0; i < TOTAL; i++) begin
            n_hits = n_hits + HIT_W'(r_hit[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_hits5 <= n_hits;
        end
    end

    // stage 6: colour times hit count
    logic [PROD_W-1:0] r_prod [3];

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_prod[0] <= PROD_W'(r_side[5][2*CB +: CB]) * PROD_W'(r_hits5);
            r_prod[1] <= PROD_W'(r_side[5][CB +: CB])   * PROD_W'(r_hits5);
            r_prod[2] <= PROD_W'(r_side[5][0 +: CB])    * PROD_W'(r_hits5);
            r_hits6   <= r_hits5;
        end
    end

    // stage 7: divide by G^2 through a rounded-up reciprocal, exact over the product range
    logic [PQ_W-1:0] n_quot [3];
    logic [CB-1:0]   r_color_out [3];
    logic [rspc_pkg::COV_BITS-1:0] r_cov;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_quot[c] = (PQ_W'(r_prod[c]) * PQ_W'(REC_M)) >> REC_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            for (int c = 0; c < 3; c++) begin
                r_color_out[c] <= CB'(n_quot[c]);
            end
            r_cov <= rspc_pkg::COV_BITS'(r_hits6);
        end
    end

    // output channel
    assign o_pix.valid     = r_vld[LAST];
    assign o_pix.out_x     = rspc_pkg::OUT_XY_BITS'(r_side[LAST][PX_LO +: COORD_BITS]);
    assign o_pix.out_y     = rspc_pkg::OUT_XY_BITS'(r_side[LAST][PY_LO +: COORD_BITS]);
    assign o_pix.coverage  = r_cov;
    assign o_pix.red_out   = r_color_out[0];
    assign o_pix.green_out = r_color_out[1];
    assign o_pix.blue_out  = r_color_out[2];

endmodule

`default_nettype wire

// ----- sv/rspc_checker.sv -----
`default_nettype none

module rspc_checker #(
    parameter int GRID_SIDE = rspc_pkg::GRID_SIDE
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [rspc_pkg::OUT_XY_BITS-1:0]    i_out_x,
    input wire logic [rspc_pkg::OUT_XY_BITS-1:0]    i_out_y,
    input wire logic [rspc_pkg::COV_BITS-1:0]       i_coverage,
    input wire logic [rspc_pkg::COLOR_BITS-1:0]     i_red_out,
    input wire logic [rspc_pkg::COLOR_BITS-1:0]     i_green_out,
    input wire logic [rspc_pkg::COLOR_BITS-1:0]     i_blue_out
);

    // full coverage count still fits the coverage field
    localparam bit COV_FITS = (GRID_SIDE * GRID_SIDE) < (1 << rspc_pkg::COV_BITS);

    // reset leaves no result on the output
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a pixel with no hits never makes a transfer
    a_cov_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && COV_FITS) |-> (i_coverage != '0))
        else $error("result with zero coverage");

    // an empty output stage means every stage can advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_coverage)
             && $stable(i_red_out) && $stable(i_green_out) && $stable(i_blue_out)))
        else $error("stalled result changed");

    // input valid only used by the reset-time view of the handshake
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_rst_n) && !$past(i_in_valid)) |-> !i_out_valid)
        else $error("result without any accepted pixel");

endmodule

bind supersampled_ring_pixel_coverage_unit rspc_checker #(
    .GRID_SIDE (GRID_SIDE)
) u_rspc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_x     (o_pix.out_x),
    .i_out_y     (o_pix.out_y),
    .i_coverage  (o_pix.coverage),
    .i_red_out   (o_pix.red_out),
    .i_green_out (o_pix.green_out),
    .i_blue_out  (o_pix.blue_out)
);

`default_nettype wire

// ----- tb/rspc_tb_pkg.sv -----
package rspc_tb_pkg;

    import rspc_pkg::*;

    // one pixel request as it crosses the input channel
    typedef struct packed {
        logic [COORD_BITS-1:0]        pixel_x;
        logic [COORD_BITS-1:0]        pixel_y;
        logic signed [COORD_BITS:0]   center_x;
        logic signed [COORD_BITS:0]   center_y;
        logic [RADIUS_BITS-1:0]       ring_radius;
        logic [COLOR_BITS-1:0]        red_in;
        logic [COLOR_BITS-1:0]        green_in;
        logic [COLOR_BITS-1:0]        blue_in;
    } pixel_req_t;

    // one shaded pixel as it leaves the block
    typedef struct packed {
        logic [OUT_XY_BITS-1:0]       out_x;
        logic [OUT_XY_BITS-1:0]       out_y;
        logic [COV_BITS-1:0]          coverage;
        logic [COLOR_BITS-1:0]        red_out;
        logic [COLOR_BITS-1:0]        green_out;
        logic [COLOR_BITS-1:0]        blue_out;
    } shaded_pixel_t;

endpackage

// ----- tb/ring_coverage_checker.sv -----
module ring_coverage_checker
    import rspc_pkg::*;
    import rspc_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [WIDTH_BITS-1:0] i_cfg_wr_data,
    input  logic                  i_done,
    rspc_in_if                    pix_in,
    rspc_out_if                   pix_out,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WIDTH_BITS-1:0] ring_width_shadow = RING_WIDTH_RESET;
    shaded_pixel_t         due_pixels[$];
    int                    fail_count   = 0;
    int                    pending      = 0;
    int                    result_count = 0;
    bit                    done_seen    = 1'b0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    // one line per failure
    task automatic report_mismatch(input string msg);
        $display("%0t ns ring checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // supersampled ring coverage, exact in 1/(32*GRID_SIDE) pixel units
    function automatic bit shade_pixel(input pixel_req_t req,
                                       input logic [WIDTH_BITS-1:0] width,
                                       output shaded_pixel_t res);
        longint sub_unit, inner, outer, inner_sq, outer_sq;
        longint off_x, off_y, sx, sy, dist_sq;
        int     hits;
        sub_unit = 32 * GRID_SIDE;
        // inner bound may go negative, squaring folds it into the hole radius
        inner    = (2 * longint'(req.ring_radius) - longint'(width)) * GRID_SIDE;
        outer    = (2 * longint'(req.ring_radius) + longint'(width)) * GRID_SIDE;
        inner_sq = inner * inner;
        outer_sq = outer * outer;
        off_x = (longint'(req.pixel_x) - longint'(req.center_x)) * sub_unit - sub_unit / 2;
        off_y = (longint'(req.pixel_y) - longint'(req.center_y)) * sub_unit - sub_unit / 2;
        hits  = 0;
        for (int a = 0; a < GRID_SIDE; a++) begin
            for (int b = 0; b < GRID_SIDE; b++) begin
                sx = off_x + 32 * a;
                sy = off_y + 32 * b;
                dist_sq = sx * sx + sy * sy;
                if (dist_sq > inner_sq && dist_sq < outer_sq)
                    hits++;
            end
        end
        res.out_x     = req.pixel_x;
        res.out_y     = req.pixel_y;
        res.coverage  = COV_BITS'(hits);
        res.red_out   = COLOR_BITS'((int'(req.red_in) * hits) / (GRID_SIDE * GRID_SIDE));
        res.green_out = COLOR_BITS'((int'(req.green_in) * hits) / (GRID_SIDE * GRID_SIDE));
        res.blue_out  = COLOR_BITS'((int'(req.blue_in) * hits) / (GRID_SIDE * GRID_SIDE));
        return hits != 0;
    endfunction

    // watch both channels and the width register
    always @(posedge i_clk) begin
        pixel_req_t    req;
        shaded_pixel_t want;
        if (!i_rst_n) begin
            ring_width_shadow <= RING_WIDTH_RESET;
            due_pixels.delete();
        end else begin
            if (i_cfg_wr_en)
                ring_width_shadow <= i_cfg_wr_data;

            // predict on every input transfer
            if (pix_in.valid && pix_in.ready) begin
                req.pixel_x     = pix_in.pixel_x;
                req.pixel_y     = pix_in.pixel_y;
                req.center_x    = pix_in.center_x;
                req.center_y    = pix_in.center_y;
                req.ring_radius = pix_in.ring_radius;
                req.red_in      = pix_in.red_in;
                req.green_in    = pix_in.green_in;
                req.blue_in     = pix_in.blue_in;
                if (shade_pixel(req, ring_width_shadow, want))
                    due_pixels.push_back(want);
            end

            // compare every output transfer with the oldest prediction
            if (pix_out.valid && pix_out.ready) begin
                result_count++;
                if (due_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected shaded pixel at (%0d,%0d)",
                                              pix_out.out_x, pix_out.out_y));
                end else begin
                    want = due_pixels.pop_front();
                    check_field("out_x", pix_out.out_x, want.out_x);
                    check_field("out_y", pix_out.out_y, want.out_y);
                    check_field("coverage", pix_out.coverage, want.coverage);
                    check_field("red_out", pix_out.red_out, want.red_out);
                    check_field("green_out", pix_out.green_out, want.green_out);
                    check_field("blue_out", pix_out.blue_out, want.blue_out);
                end
            end

            // leftovers at end of test
            if (i_done && !done_seen) begin
                done_seen <= 1'b1;
                if (due_pixels.size() != 0)
                    report_mismatch($sformatf("%0d shaded pixels never arrived",
                                              due_pixels.size()));
            end
        end
        pending = due_pixels.size();
    end

endmodule

// ----- tb/tb_supersampled_ring_pixel_coverage_unit.sv -----
module tb_supersampled_ring_pixel_coverage_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rspc_pkg::*;
    import rspc_tb_pkg::*;

    localparam int PIPE_LATENCY  = 8;
    localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 60;
    localparam int CTR_W         = COORD_BITS + 1;
    localparam int PIX_MAX       = (1 << COORD_BITS) - 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [WIDTH_BITS-1:0] cfg_wr_data = '0;
    logic                  run_done    = 1'b0;

    int                    fail_count;
    int                    pending;
    int                    result_count;

    int                    src_idle_pct   = 0;
    int                    snk_stall_pct  = 0;
    bit                    pressure_on    = 1'b0;
    logic [WIDTH_BITS-1:0] cur_width      = RING_WIDTH_RESET;
    int                    items_sent     = 0;
    int                    width_writes   = 0;
    int                    blocked_cycles = 0;
    int                    holdoff_cycles = 0;
    int                    cycle_count    = 0;

    rspc_in_if  pix_in ();
    rspc_out_if pix_out ();

    supersampled_ring_pixel_coverage_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_pix         (pix_in),
        .o_pix         (pix_out)
    );

    ring_coverage_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_done         (run_done),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_supersampled_ring_pixel_coverage_unit: done, errors");
            $finish;
        end
    end

    // output side: random stalls, or long hold-offs while pressure is on
    initial begin : output_sink
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        pix_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_on) begin
                if (hold_left == 0 && run_left == 0) begin
                    hold_left = LONG_HOLD;
                    run_left  = 40;
                end
                if (hold_left != 0) begin
                    hold_left--;
                    holdoff_cycles++;
                    pix_out.ready <= 1'b0;
                end else begin
                    run_left--;
                    pix_out.ready <= 1'b1;
                end
            end else begin
                pix_out.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic int isqrt(input int v);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    // colours lean on the extremes now and then
    function automatic logic [COLOR_BITS-1:0] pick_colour();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return COLOR_BITS'($urandom);
        endcase
    endfunction

    function automatic pixel_req_t make_pixel(input int px, input int py, input int cx,
                                              input int cy, input int r, input int red,
                                              input int grn, input int blu);
        pixel_req_t req;
        req.pixel_x     = COORD_BITS'(px);
        req.pixel_y     = COORD_BITS'(py);
        req.center_x    = CTR_W'(cx);
        req.center_y    = CTR_W'(cy);
        req.ring_radius = RADIUS_BITS'(r);
        req.red_in      = COLOR_BITS'(red);
        req.green_in    = COLOR_BITS'(grn);
        req.blue_in     = COLOR_BITS'(blu);
        return req;
    endfunction

    // fully random fields, mostly far from any ring
    function automatic pixel_req_t noise_pixel();
        pixel_req_t req;
        req.pixel_x     = COORD_BITS'($urandom);
        req.pixel_y     = COORD_BITS'($urandom);
        req.center_x    = CTR_W'($urandom);
        req.center_y    = CTR_W'($urandom);
        req.ring_radius = RADIUS_BITS'($urandom);
        req.red_in      = pick_colour();
        req.green_in    = pick_colour();
        req.blue_in     = pick_colour();
        return req;
    endfunction

    // place the centre so the pixel sits at the given offset from it
    function automatic pixel_req_t offset_center(input pixel_req_t req, input int off_x,
                                                 input int off_y);
        if (int'(req.pixel_x) - off_x > PIX_MAX)
            off_x = -off_x;
        if (int'(req.pixel_y) - off_y > PIX_MAX)
            off_y = -off_y;
        req.center_x = CTR_W'(int'(req.pixel_x) - off_x);
        req.center_y = CTR_W'(int'(req.pixel_y) - off_y);
        return req;
    endfunction

    // pixel placed on or near the ring stroke
    function automatic pixel_req_t ring_pixel();
        pixel_req_t req;
        int radius, reach, dist_px, off_x, off_y;
        req    = noise_pixel();
        radius = ($urandom_range(9) == 0) ? int'($urandom_range(4095))
                                          : int'($urandom_range(800));
        req.ring_radius = RADIUS_BITS'(radius);
        // distance from 1/32 pixel units down to whole pixels, jittered a little past the stroke edges
        reach   = int'(cur_width) + 48;
        dist_px = (2 * radius + int'($urandom_range(2 * reach)) - reach) / 32;
        if (dist_px < 0)
            dist_px = -dist_px;
        off_x = int'($urandom_range(dist_px));
        off_y = isqrt(dist_px * dist_px - off_x * off_x);
        if ($urandom_range(1))
            off_x = -off_x;
        if ($urandom_range(1))
            off_y = -off_y;
        return offset_center(req, off_x, off_y);
    endfunction

    // pixel close to the centre of a small ring, often inside the hole
    function automatic pixel_req_t hole_pixel();
        pixel_req_t req;
        req = noise_pixel();
        req.ring_radius = RADIUS_BITS'($urandom_range(64));
        return offset_center(req, int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3);
    endfunction

    function automatic pixel_req_t random_pixel();
        int pick;
        pick = int'($urandom_range(99));
        if (pick < 75)
            return ring_pixel();
        if (pick < 85)
            return hole_pixel();
        return noise_pixel();
    endfunction

    // offer one request and hold it until the transfer
    task automatic send_pixel(input pixel_req_t req);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.pixel_x     <= req.pixel_x;
        pix_in.pixel_y     <= req.pixel_y;
        pix_in.center_x    <= req.center_x;
        pix_in.center_y    <= req.center_y;
        pix_in.ring_radius <= req.ring_radius;
        pix_in.red_in      <= req.red_in;
        pix_in.green_in    <= req.green_in;
        pix_in.blue_in     <= req.blue_in;
        @(posedge i_clk);
        while (!pix_in.ready) begin
            blocked_cycles++;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // wait for every prediction, then let no-result pixels leave the pipe
    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_width(input logic [WIDTH_BITS-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_width = w;
        width_writes++;
    endtask

    task automatic run_phase(input logic [WIDTH_BITS-1:0] w, input int src_pct,
                             input int snk_pct, input int count, input bit squeeze);
        drain_pipe();
        write_ring_width(w);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        pressure_on   = squeeze;
        repeat (count) send_pixel(random_pixel());
    endtask

    // stimulus and verdict
    initial begin
        pix_in.valid       = 1'b0;
        pix_in.pixel_x     = '0;
        pix_in.pixel_y     = '0;
        pix_in.center_x    = '0;
        pix_in.center_y    = '0;
        pix_in.ring_radius = '0;
        pix_in.red_in      = '0;
        pix_in.green_in    = '0;
        pix_in.blue_in     = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at the reset width of 4 pixels
        send_pixel(make_pixel(0, 0, 0, 0, 32, 255, 255, 255));
        send_pixel(make_pixel(1023, 1023, 1023, 1023, 0, 255, 255, 255));
        send_pixel(make_pixel(110, 100, 100, 100, 160, 255, 255, 255));
        send_pixel(make_pixel(110, 100, 100, 100, 160, 1, 15, 16));
        send_pixel(make_pixel(1023, 767, 1023, 1023, 4095, 128, 127, 255));
        send_pixel(make_pixel(0, 0, -1024, -1024, 4095, 255, 0, 255));
        send_pixel(make_pixel(1023, 0, -1024, 1023, 0, 0, 255, 0));
        // mid radius below half the width: hole around the centre
        send_pixel(make_pixel(101, 100, 100, 100, 16, 200, 100, 50));
        send_pixel(make_pixel(100, 100, 100, 100, 16, 200, 100, 50));
        send_pixel(make_pixel(103, 100, 100, 100, 16, 200, 100, 50));
        send_pixel(make_pixel(682, 341, -341, 682, 2730, 170, 85, 15));
        send_pixel(make_pixel(341, 682, 341, 597, 1365, 85, 170, 240));
        send_pixel(make_pixel(341, 682, 341, 597, 1365, 0, 0, 0));
        send_pixel(make_pixel(0, 5, -10, 5, 160, 17, 34, 51));
        send_pixel(make_pixel(5, 0, 15, 0, 160, 255, 254, 253));
        send_pixel(make_pixel(300, 300, 290, 290, 226, 99, 77, 33));

        // random phases: width, sender idle, receiver stall, items, pressure
        run_phase(8'd255, 60, 0, 130, 1'b0);
        run_phase(8'd1, 0, 60, 130, 1'b0);
        run_phase(8'd0, 18, 18, 40, 1'b0);
        run_phase(WIDTH_BITS'($urandom), 18, 18, 130, 1'b0);
        run_phase(8'd64, 0, 0, 100, 1'b1);
        run_phase(WIDTH_BITS'($urandom_range(8, 128)), 0, 0, 200, 1'b0);

        drain_pipe();
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("covered %0d pixel requests under %0d width writes, %0d shaded pixels checked",
                 items_sent, width_writes, result_count);
        $display("input stalled %0d cycles, output held off %0d cycles in long stretches",
                 blocked_cycles, holdoff_cycles);
        if (fail_count == 0) begin
            $display("tb_supersampled_ring_pixel_coverage_unit: done, clean");
        end else begin
            $display("tb_supersampled_ring_pixel_coverage_unit: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/rspc_pkg.sv
sv/rspc_ifs.sv
sv/supersampled_ring_pixel_coverage_unit.sv
sv/rspc_checker.sv
tb/rspc_tb_pkg.sv
tb/ring_coverage_checker.sv
tb/tb_supersampled_ring_pixel_coverage_unit.sv
